// ===== rtl/core/wis_pkg.sv =====
// ---------------------------------------------------------------------------
// wis_pkg - shared types and helpers for the weighted increasing subsequence
// Field widths, the slot count, the beat types of both channels and of the
// cell chain, and the saturating add used by the cells and the output stage.
// ---------------------------------------------------------------------------
`default_nettype none

package wis_pkg;

    // slot count and field widths
    localparam int SLOTS  = 1024;
    localparam int KEY_W  = 10;
    localparam int WGT_W  = 32;
    localparam int BEST_W = 48;
    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CMP_W  = (KEY_W > IDX_W) ? KEY_W : IDX_W;

    // input channel beat
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [WGT_W-1:0] weight;
    } t_in;

    // output channel beat
    typedef struct packed {
        logic [BEST_W-1:0] best_here;
        logic [BEST_W-1:0] best_overall;
    } t_out;

    // beat handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic              hit;
        logic [KEY_W-1:0]  key;
        logic [WGT_W-1:0]  weight;
        logic [BEST_W-1:0] acc;
    } t_beat;

    // prefix max plus weight, clamped to the field maximum
    function automatic logic [BEST_W-1:0] sat_add(input logic [BEST_W-1:0] a,
                                                   input logic [WGT_W-1:0]  w);
        logic [BEST_W:0] s;
        s = {1'b0, a} + {{(BEST_W+1-WGT_W){1'b0}}, w};
        return s[BEST_W] ? {BEST_W{1'b1}} : s[BEST_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/wis_cell.sv =====
// ---------------------------------------------------------------------------
// wis_cell - one slot of the key-ordered chain
// Holds the best value of its slot. A beat for a larger key picks up the
// running prefix max; a beat for this key stores the saturated sum.
// ---------------------------------------------------------------------------
`default_nettype none

module wis_cell
    import wis_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_adv,
    input  wire logic [CMP_W-1:0] i_index,
    input  wire t_beat            i_beat,
    output t_beat                 o_beat
);

    logic [BEST_W-1:0] r_best;
    logic [BEST_W-1:0] n_best;
    t_beat             r_beat;
    t_beat             n_beat;
    logic [CMP_W-1:0]  key_ext;
    logic [BEST_W-1:0] sum;

    assign key_ext = CMP_W'(i_beat.key);
    assign sum     = sat_add(i_beat.acc, i_beat.weight);

    // prefix max below the key, store at the key
    always_comb begin
        n_beat = i_beat;
        n_best = r_best;
        if (i_beat.valid && !i_beat.hit) begin
            if (i_index < key_ext) begin
                if (r_best > i_beat.acc) begin
                    n_beat.acc = r_best;
                end
            end else if (i_index == key_ext) begin
                n_beat.acc = sum;
                n_beat.hit = 1'b1;
                n_best     = sum;
            end
        end
    end

    // slot value and beat register, frozen while the chain stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best <= '0;
            r_beat <= '0;
        end else if (i_adv) begin
            r_best <= n_best;
            r_beat <= n_beat;
        end
    end

    assign o_beat = r_beat;

endmodule

`default_nettype wire

// ===== rtl/core/wis_out.sv =====
// ---------------------------------------------------------------------------
// wis_out - output register and running maximum
// Finishes the sum of beats whose key lies beyond the store, keeps the
// overall best and drives the output channel. Sets the chain advance.
// ---------------------------------------------------------------------------
`default_nettype none

module wis_out
    import wis_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_beat i_beat,
    input  wire logic  i_out_ready,
    output logic       o_adv,
    output logic       o_out_valid,
    output t_out       o_out_data
);

    logic              r_valid;
    t_out              r_data;
    logic [BEST_W-1:0] r_overall;
    logic [BEST_W-1:0] n_overall;
    logic [BEST_W-1:0] here;

    // chain moves when the output register is empty or being taken
    assign o_adv = !r_valid || i_out_ready;

    // result of the beat leaving the last cell
    always_comb begin
        n_overall = r_overall;
        here      = i_beat.hit ? i_beat.acc : sat_add(i_beat.acc, i_beat.weight);
        if (i_beat.valid && i_beat.hit && (i_beat.acc > r_overall)) begin
            n_overall = i_beat.acc;
        end
    end

    // output beat and running maximum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_overall <= '0;
        end else if (o_adv) begin
            r_valid   <= i_beat.valid;
            r_overall <= n_overall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_data.best_here    <= here;
            r_data.best_overall <= n_overall;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

`default_nettype wire

// ===== rtl/core/weighted_increasing_subsequence.sv =====
// ---------------------------------------------------------------------------
// weighted_increasing_subsequence - streaming max-weight increasing chain
// Key-ordered systolic chain of slot cells feeding an output register.
// ---------------------------------------------------------------------------
// A new item is accepted every cycle unless the output stalls: each beat
// walks a chain of SLOTS cells, one cell per cycle, gathering the prefix max
// of the slots below its key and storing its sum in its own slot, so every
// beat sees all earlier writes. From input accept to output valid a beat
// passes the SLOTS cell registers and then the output register. A stall on
// the output freezes the whole chain and drops input ready. The slot store
// is cleared by reset.
`default_nettype none

module weighted_increasing_subsequence
    import wis_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);

    t_beat chain [0:SLOTS];
    logic  adv;

    // entry beat, prefix max starts at zero
    assign chain[0] = {i_in_valid, 1'b0, i_in_data.key, i_in_data.weight, {BEST_W{1'b0}}};

    // no beat is taken while reset holds the chain
    assign o_in_ready = adv && i_rst_n;

    // one cell per slot
    for (genvar k = 0; k < SLOTS; k++) begin : g_cell
        wis_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_index (CMP_W'(k)),
            .i_beat  (chain[k]),
            .o_beat  (chain[k+1])
        );
    end

    // output register and overall best
    wis_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_beat      (chain[SLOTS]),
        .i_out_ready (i_out_ready),
        .o_adv       (adv),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ===== tb/sv/weighted_increasing_subsequence_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// weighted_increasing_subsequence_tb - self-checking bench for the chain block
// Drives (key, weight) beats through valid/ready and predicts every result
// beat from an own copy of the per-key best store and the running maximum.
// A short directed table comes first, then randomized chains and noise in
// four idling phases. A long output hold-off fills the chain and stalls the
// input, and the sender drains the block between phases.
// ---------------------------------------------------------------------------

module weighted_increasing_subsequence_tb;
    import wis_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int LONG_HOLD     = 3000;
    localparam int PHASE_ITEMS   = 360;
    localparam int END_WAIT      = SLOTS + 64;
    localparam int DIR_ROWS      = 16;
    localparam logic [BEST_W-1:0] BEST_MAX = '1;

    // one row of the directed table
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [WGT_W-1:0]  weight;
        logic              typed;
        logic [BEST_W-1:0] here;
        logic [BEST_W-1:0] overall;
    } t_dir_row;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_in  i_in_data   = '0;
    logic i_out_ready = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_data;

    // predictor state
    logic [BEST_W-1:0] slot_best [SLOTS];
    logic [BEST_W-1:0] running_best;
    t_out              pending_results [$];

    // random stimulus state
    logic [KEY_W-1:0]  run_key;
    logic [KEY_W-1:0]  recent_keys [8];
    logic [2:0]        recent_ptr;

    // idling knobs
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    bit   long_hold_req  = 1'b0;
    int   hold_left      = 0;
    int   error_count    = 0;
    int   cycle_count    = 0;

    // directed rows; the first five follow straight from an empty store
    t_dir_row dir_tab [DIR_ROWS] = '{
        '{10'd0,    32'h0000_0000, 1'b1, 48'h0,           48'h0},
        '{10'd0,    32'hFFFF_FFFF, 1'b1, 48'hFFFF_FFFF,   48'hFFFF_FFFF},
        '{10'd1023, 32'hFFFF_FFFF, 1'b1, 48'h1_FFFF_FFFE, 48'h1_FFFF_FFFE},
        '{10'd1023, 32'h0000_0000, 1'b1, 48'hFFFF_FFFF,   48'h1_FFFF_FFFE},
        '{10'd0,    32'h0000_0001, 1'b1, 48'h1,           48'h1_FFFF_FFFE},
        '{10'd512,  32'h5555_5555, 1'b0, 48'h0,           48'h0},
        '{10'd511,  32'hAAAA_AAAA, 1'b0, 48'h0,           48'h0},
        '{10'd513,  32'hFFFF_FFFF, 1'b0, 48'h0,           48'h0},
        '{10'd1,    32'h0000_0002, 1'b0, 48'h0,           48'h0},
        '{10'd1022, 32'h1234_5678, 1'b0, 48'h0,           48'h0},
        '{10'd341,  32'h0000_FFFF, 1'b0, 48'h0,           48'h0},
        '{10'd682,  32'hFFFF_0000, 1'b0, 48'h0,           48'h0},
        '{10'd1023, 32'hFFFF_FFFF, 1'b0, 48'h0,           48'h0},
        '{10'd2,    32'h0000_0000, 1'b0, 48'h0,           48'h0},
        '{10'd1,    32'h0000_0000, 1'b0, 48'h0,           48'h0},
        '{10'd1023, 32'h0000_0001, 1'b0, 48'h0,           48'h0}
    };

    weighted_increasing_subsequence DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // best chain ending at this item, and update of the store
    function automatic t_out chain_predict(input t_in item);
        logic [BEST_W-1:0] prefix;
        logic [BEST_W:0]   sum;
        t_out              res;
        prefix = '0;
        for (int k = 0; k < SLOTS; k++) begin
            if (k < item.key && slot_best[k] > prefix)
                prefix = slot_best[k];
        end
        sum = {1'b0, prefix} + (BEST_W + 1)'(item.weight);
        res.best_here = (sum > {1'b0, BEST_MAX}) ? BEST_MAX : sum[BEST_W-1:0];
        // keys past the store only read it
        if (item.key < SLOTS) begin
            slot_best[item.key] = res.best_here;
            if (res.best_here > running_best)
                running_best = res.best_here;
        end
        res.best_overall = running_best;
        return res;
    endfunction

    // mostly ascending runs that build chains, plus repeats and noise
    function automatic t_in next_random_item();
        t_in item;
        int  mode;
        int  wsel;
        mode = $urandom_range(0, 99);
        if (mode < 45) begin
            run_key = run_key + KEY_W'($urandom_range(1, 6));
            item.key = run_key;
        end else if (mode < 65) begin
            item.key = KEY_W'($urandom());
        end else if (mode < 80) begin
            item.key = recent_keys[$urandom_range(0, 7)];
        end else begin
            item.key = run_key - KEY_W'($urandom_range(1, 40));
        end
        wsel = $urandom_range(0, 99);
        if (wsel < 40)
            item.weight = WGT_W'($urandom_range(0, 255));
        else if (wsel < 75)
            item.weight = $urandom();
        else if (wsel < 85)
            item.weight = '1;
        else if (wsel < 92)
            item.weight = '0;
        else
            item.weight = 32'hFFFF_0000 | WGT_W'($urandom_range(0, 65535));
        recent_keys[recent_ptr] = item.key;
        recent_ptr = recent_ptr + 3'd1;
        return item;
    endfunction

    // offer one input beat, with random gaps before it
    task automatic send_item(input t_in item, input bit typed, input t_out typed_res);
        t_out pred;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        pred = chain_predict(item);
        pending_results.push_back(typed ? typed_res : pred);
    endtask

    // drop valid and wait until every pending result has come
    task automatic drain_block();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // compare each result beat with the oldest pending result
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result beat: best_here %0h best_overall %0h",
                       o_out_data.best_here, o_out_data.best_overall);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.best_here !== want.best_here) begin
                    $error("best_here: expected %0h, got %0h",
                           want.best_here, o_out_data.best_here);
                    error_count++;
                end
                if (o_out_data.best_overall !== want.best_overall) begin
                    $error("best_overall: expected %0h, got %0h",
                           want.best_overall, o_out_data.best_overall);
                    error_count++;
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // main sequence
    initial begin
        t_in  item;
        t_out typed_res;
        for (int k = 0; k < SLOTS; k++)
            slot_best[k] = '0;
        running_best = '0;
        run_key      = '0;
        recent_ptr   = '0;
        for (int k = 0; k < 8; k++)
            recent_keys[k] = '0;

        // reset
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, no idling
        for (int r = 0; r < DIR_ROWS; r++) begin
            item.key               = dir_tab[r].key;
            item.weight            = dir_tab[r].weight;
            typed_res.best_here    = dir_tab[r].here;
            typed_res.best_overall = dir_tab[r].overall;
            send_item(item, dir_tab[r].typed, typed_res);
        end
        drain_block();

        // random phases: none, sender idle, receiver stall, both light
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 88;
                    recv_stall_pct = 0;
                    // long output hold-off outlasting the chain, so ready drops
                    // while the sender keeps offering
                    long_hold_req  = 1'b1;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 88;
                end
                default: begin
                    send_idle_pct  = 8;
                    recv_stall_pct = 8;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(next_random_item(), 1'b0, typed_res);
            drain_block();
        end

        // quiet tail to catch stray beats
        repeat (END_WAIT) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
